/* rtl/rscm_pkg.sv */
package rscm_pkg;

    // Fixed field widths of the item and configuration formats
    localparam int ROW_W      = 4;   // pattern_row
    localparam int COL_W      = 3;   // pattern_col
    localparam int KEY_IN_W   = 32;  // key as carried on the input channel
    localparam int OUT_W      = 16;  // list_row
    localparam int ROWS_CFG_W = 5;   // pattern_rows_used
    localparam int COLS_CFG_W = 4;   // pattern_cols_used
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int S_TDATA_W  = 40;  // row, col, key packed, padded to whole bytes

    // Opcode carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_LIST = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b1;

    // Control word handed from cell to cell along with the key
    typedef struct packed {
        logic             valid;
        logic             is_load;   // pattern load that lands inside the table
        logic             is_list;   // list row key
        logic             row_end;
        logic             hit;       // some earlier cell found a whole pattern row
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } ctl_t;

endpackage

/* rtl/rscm_cell.sv */
module rscm_cell #(
    parameter int ROW_ID     = 0,
    parameter int COLS       = 8,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic [rscm_pkg::ROWS_CFG_W-1:0]     rows_used,
    input  logic [rscm_pkg::COLS_CFG_W-1:0]     cols_used,
    input  rscm_pkg::ctl_t                      ctl_in,
    input  logic [KEY_WIDTH-1:0]                key_in,
    output rscm_pkg::ctl_t                      ctl_out,
    output logic [KEY_WIDTH-1:0]                key_out
);

    logic [KEY_WIDTH-1:0] entry_reg [COLS];
    logic [COLS-1:0]      seen_reg;
    logic [COLS-1:0]      match;
    logic                 all_seen;
    logic                 row_sel;
    logic                 row_active;
    logic                 step;
    rscm_pkg::ctl_t       ctl_next;
    rscm_pkg::ctl_t       ctl_reg;
    logic [KEY_WIDTH-1:0] key_reg;

    assign step       = advance && ctl_in.valid;
    assign row_sel    = 32'(ctl_in.row) == 32'(ROW_ID);
    assign row_active = 32'(ROW_ID) < 32'(rows_used);

    // Compare the passing key with every entry of this row at once
    for (genvar c = 0; c < COLS; c++) begin : g_col
        assign match[c] = entry_reg[c] == key_in;

        always_ff @(posedge clk)
        begin
            if (step && ctl_in.is_load && row_sel && 32'(ctl_in.col) == 32'(c))
            begin
                entry_reg[c] <= key_in;
            end
        end
    end

    always_comb
    begin
        all_seen = 1'b1;
        for (int c = 0; c < COLS; c++)
        begin
            if (32'(c) < 32'(cols_used) && !(seen_reg[c] || match[c]))
            begin
                all_seen = 1'b0;
            end
        end
        ctl_next     = ctl_in;
        ctl_next.hit = ctl_in.hit ||
                       (ctl_in.is_list && ctl_in.row_end && row_active && all_seen);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            ctl_reg  <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
            if (ctl_in.valid)
            begin
                if (ctl_in.is_load || (ctl_in.is_list && ctl_in.row_end))
                begin
                    seen_reg <= '0;
                end
                else if (ctl_in.is_list)
                begin
                    seen_reg <= seen_reg | match;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg <= key_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign key_out = key_reg;

endmodule

/* rtl/row_set_containment_match_unit.sv */
// Set-containment row matcher.
//
// Load pattern keys with tuser = 0 (tdata: row, column, key). Each in-table
// load clears the list row counter and all seen marks. Stream list rows with
// tuser = 1, one key per item, tlast on the last key of each row. When a
// row ends and every key in the used columns of at least one used pattern
// row was seen in it, the 1-based row number leaves on the master channel.
// Loads outside the table are taken and dropped.
//
// The slave channel takes one item per cycle unless the chain stalls. Each
// item walks a chain of PATTERN_ROWS registered cells, one cell per cycle
// while the chain advances; the row counter and the output register load as
// it leaves the last cell. The chain stalls only while a result waits
// unaccepted and the item at the chain end would produce another one.
//
// Reset clears the seen marks, the counter, both registers and all valid
// flags; pattern keys stay undefined until loaded. Write the registers
// through the cfg channel only while no item is in flight.
module row_set_containment_match_unit #(
    parameter int              PATTERN_ROWS = 16,
    parameter int              PATTERN_COLS = 8,
    parameter int              KEY_WIDTH    = 32,
    parameter longint unsigned ROW_LIMIT    = 65535
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // pattern_row [3:0], pattern_col [6:4], key [38:7], zero pad [39]
    input  logic [rscm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // opcode [0]
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // list_row [15:0]
    output logic [rscm_pkg::OUT_W-1:0]         m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rscm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rscm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(ROW_LIMIT + 1);

    logic [rscm_pkg::ROWS_CFG_W-1:0] rows_used_reg;
    logic [rscm_pkg::COLS_CFG_W-1:0] cols_used_reg;

    rscm_pkg::ctl_t       ctl_chain [PATTERN_ROWS+1];
    logic [KEY_WIDTH-1:0] key_chain [PATTERN_ROWS];

    logic [rscm_pkg::ROW_W-1:0]    in_row;
    logic [rscm_pkg::COL_W-1:0]    in_col;
    logic [rscm_pkg::KEY_IN_W-1:0] in_key;
    logic                          in_range;

    rscm_pkg::ctl_t     tail;
    logic               emit;
    logic               advance;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   cnt_bumped;
    logic               out_valid_reg;
    logic [rscm_pkg::OUT_W-1:0] out_data_reg;

    // Configuration: always ready, registers consulted only at row end
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= '0;
            cols_used_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rscm_pkg::CFG_ROWS_USED: rows_used_reg <= cfg_data;
                rscm_pkg::CFG_COLS_USED: cols_used_reg <= cfg_data[rscm_pkg::COLS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the item and turn it into the control word for the first cell
    assign in_row   = s_axis_tdata[rscm_pkg::ROW_W-1:0];
    assign in_col   = s_axis_tdata[rscm_pkg::ROW_W +: rscm_pkg::COL_W];
    assign in_key   = s_axis_tdata[rscm_pkg::ROW_W + rscm_pkg::COL_W +: rscm_pkg::KEY_IN_W];
    assign in_range = 32'(in_row) < 32'(PATTERN_ROWS) && 32'(in_col) < 32'(PATTERN_COLS);

    always_comb
    begin
        ctl_chain[0].valid   = s_axis_tvalid;
        ctl_chain[0].is_load = (s_axis_tuser == rscm_pkg::OP_LOAD) && in_range;
        ctl_chain[0].is_list = s_axis_tuser == rscm_pkg::OP_LIST;
        ctl_chain[0].row_end = s_axis_tlast;
        ctl_chain[0].hit     = 1'b0;
        ctl_chain[0].row     = in_row;
        ctl_chain[0].col     = in_col;
    end

    // Chain of cells, one per pattern row; the key rides along with its control word
    for (genvar r = 0; r < PATTERN_ROWS; r++) begin : g_cell
        if (r == PATTERN_ROWS - 1) begin : g_last
            rscm_cell #(
                .ROW_ID    (r),
                .COLS      (PATTERN_COLS),
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .rows_used (rows_used_reg),
                .cols_used (cols_used_reg),
                .ctl_in    (ctl_chain[r]),
                .key_in    ((r == 0) ? KEY_WIDTH'(in_key) : key_chain[r]),
                .ctl_out   (ctl_chain[r+1]),
                .key_out   ()
            );
        end
        else begin : g_mid
            rscm_cell #(
                .ROW_ID    (r),
                .COLS      (PATTERN_COLS),
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .rows_used (rows_used_reg),
                .cols_used (cols_used_reg),
                .ctl_in    (ctl_chain[r]),
                .key_in    ((r == 0) ? KEY_WIDTH'(in_key) : key_chain[r]),
                .ctl_out   (ctl_chain[r+1]),
                .key_out   (key_chain[r+1])
            );
        end
    end

    assign key_chain[0] = KEY_WIDTH'(in_key);

    // Chain end: count rows and emit matching row numbers
    assign tail    = ctl_chain[PATTERN_ROWS];
    assign emit    = tail.valid && tail.is_list && tail.row_end && tail.hit;
    // Hold the whole chain only while a result waits and another one is due
    assign advance = !(out_valid_reg && !m_axis_tready && emit);
    assign s_axis_tready = advance;

    assign cnt_bumped = (cnt_reg == CNT_W'(ROW_LIMIT)) ? cnt_reg : cnt_reg + CNT_W'(1);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (tail.valid && tail.is_load)
        begin
            cnt_next = '0;
        end
        else if (tail.valid && tail.is_list && tail.row_end)
        begin
            cnt_next = cnt_bumped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                cnt_reg <= cnt_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= rscm_pkg::OUT_W'(cnt_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Counter never passes its limit
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ROW_LIMIT))
        else $error("row counter above limit");

    // A load leaving the chain restarts the row count
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tail.valid && tail.is_load) |=> (cnt_reg == '0))
        else $error("row counter not cleared by load");

    // A matching row end always lands in the output register
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> m_axis_tvalid)
        else $error("matching row lost");

    // The input side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

endmodule
